@@ hdl/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants for the binary frame sync / byte-sum check block.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned SumW   = 16;
  localparam int unsigned StatW  = 3;

  localparam logic [ByteW-1:0] HdrStart  = 8'h01;
  localparam logic [ByteW-1:0] CompMask  = 8'hFF;
  localparam logic [IdxW-1:0]  LenBias   = 9'd6;
  localparam logic [IdxW-1:0]  LenIdx    = 9'd3;
  localparam logic [IdxW-1:0]  ObsIdx    = 9'd6;
  localparam logic [IdxW-1:0]  MaxLenRst = 9'd261;

  // known message ids and their lengths
  localparam logic [ByteW-1:0] Id20 = 8'd20;
  localparam logic [ByteW-1:0] Id21 = 8'd21;
  localparam logic [ByteW-1:0] Id22 = 8'd22;
  localparam logic [ByteW-1:0] Id23 = 8'd23;
  localparam logic [ByteW-1:0] Id67 = 8'd67;
  localparam logic [11:0] Len20 = 12'd77;
  localparam logic [11:0] Len21 = 12'd85;
  localparam logic [11:0] Len22 = 12'd79;
  localparam logic [11:0] Len67 = 12'd54;
  localparam logic [11:0] Len23Base = 12'd17;

  // verdict codes
  localparam logic [StatW-1:0] StBusy     = 3'd0;
  localparam logic [StatW-1:0] StKnownOk  = 3'd1;
  localparam logic [StatW-1:0] StUnkOk    = 3'd2;
  localparam logic [StatW-1:0] StCksBad   = 3'd3;
  localparam logic [StatW-1:0] StTooLong  = 3'd4;
  localparam logic [StatW-1:0] StLenBad   = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [IdxW-1:0]  index;
    logic [ByteW-1:0] id;
    logic             last;
    logic [StatW-1:0] status;
  } result_t;

endpackage

@@ hdl/bfs_core.sv @@
// ----------------------------------------------------------------------------
// bfs_core
// Header hunt, frame byte counter, running byte sum and end-of-frame verdict.
// ----------------------------------------------------------------------------
module bfs_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [bfs_pkg::ByteW-1:0]       din,
  input  logic [bfs_pkg::IdxW-1:0]        max_len,
  output logic                            res_valid,
  output bfs_pkg::result_t                res
);

  logic [23:0]               win_r, win_nxt;
  logic [bfs_pkg::IdxW-1:0]  cnt_r, cnt_nxt;
  logic [bfs_pkg::IdxW-1:0]  len_r, len_nxt;
  logic [bfs_pkg::SumW-1:0]  sum_r, sum_nxt;
  logic [bfs_pkg::ByteW-1:0] low_r, low_nxt;
  logic [bfs_pkg::ByteW-1:0] obs_r, obs_nxt;

  logic                      hunt;
  logic [23:0]               win_shift;
  logic                      hdr_hit;
  logic [bfs_pkg::IdxW-1:0]  len_cur;
  logic [bfs_pkg::ByteW-1:0] obs_cur;
  logic                      too_long;
  logic [bfs_pkg::IdxW:0]    idx_p1, idx_p2, len_ext;
  logic                      sum_add, low_set, fin;
  logic                      cks_ok;
  logic [11:0]               want;
  logic                      known;
  logic [bfs_pkg::StatW-1:0] verdict;

  assign hunt      = (cnt_r == '0);
  assign win_shift = {win_r[15:0], din};
  assign hdr_hit   = (win_shift[23:16] == bfs_pkg::HdrStart) &&
                     ((win_shift[15:8] ^ win_shift[7:0]) == bfs_pkg::CompMask);

  // length byte takes effect on the same transaction
  assign len_cur  = (cnt_r == bfs_pkg::LenIdx) ? ({1'b0, din} + bfs_pkg::LenBias) : len_r;
  assign too_long = (cnt_r == bfs_pkg::LenIdx) && (len_cur > max_len);
  assign obs_cur  = (cnt_r == bfs_pkg::ObsIdx) ? din : obs_r;

  assign idx_p1  = {1'b0, cnt_r} + 10'd1;
  assign idx_p2  = {1'b0, cnt_r} + 10'd2;
  assign len_ext = {1'b0, len_cur};
  assign sum_add = (idx_p2 < len_ext);
  assign low_set = (idx_p2 == len_ext);
  assign fin     = (idx_p1 >= len_ext);

  assign cks_ok = (sum_r[7:0] == low_r) && (sum_r[15:8] == din);

  always_comb begin
    known = 1'b1;
    want  = '0;
    unique case (win_r[15:8])
      bfs_pkg::Id20: want = bfs_pkg::Len20;
      bfs_pkg::Id21: want = bfs_pkg::Len21;
      bfs_pkg::Id22: want = bfs_pkg::Len22;
      bfs_pkg::Id23: want = bfs_pkg::Len23Base + ({4'd0, obs_cur} * 12'd11);
      bfs_pkg::Id67: want = bfs_pkg::Len67;
      default:       known = 1'b0;
    endcase
  end

  always_comb begin
    if (!cks_ok) begin
      verdict = bfs_pkg::StCksBad;
    end else if (!known) begin
      verdict = bfs_pkg::StUnkOk;
    end else if (want == {3'd0, len_cur}) begin
      verdict = bfs_pkg::StKnownOk;
    end else begin
      verdict = bfs_pkg::StLenBad;
    end
  end

  always_comb begin
    res_valid  = step && !hunt;
    res.data   = din;
    res.index  = cnt_r;
    res.id     = win_r[15:8];
    res.last   = too_long || fin;
    res.status = too_long ? bfs_pkg::StTooLong : (fin ? verdict : bfs_pkg::StBusy);
  end

  always_comb begin
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    sum_nxt = sum_r;
    low_nxt = low_r;
    obs_nxt = obs_r;
    if (step) begin
      if (hunt) begin
        win_nxt = win_shift;
        if (hdr_hit) begin
          cnt_nxt = bfs_pkg::LenIdx;
          sum_nxt = {8'd0, win_shift[23:16]} + {8'd0, win_shift[15:8]} +
                    {8'd0, win_shift[7:0]};
          obs_nxt = '0;
          low_nxt = '0;
        end
      end else begin
        len_nxt = len_cur;
        if (too_long) begin
          cnt_nxt = '0;
        end else begin
          obs_nxt = obs_cur;
          if (sum_add) begin
            sum_nxt = sum_r + {8'd0, din};
          end else if (low_set) begin
            low_nxt = din;
          end
          cnt_nxt = fin ? '0 : idx_p1[bfs_pkg::IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
      len_r <= '0;
      sum_r <= '0;
      low_r <= '0;
      obs_r <= '0;
    end else begin
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      low_r <= low_nxt;
      obs_r <= obs_nxt;
    end
  end

endmodule

@@ hdl/bfs_out_reg.sv @@
// ----------------------------------------------------------------------------
// bfs_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
module bfs_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  bfs_pkg::result_t din,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output bfs_pkg::result_t dout
);

  logic             vld_r, vld_nxt;
  bfs_pkg::result_t res_r;

  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (free) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= din;
    end
  end

  assign out_valid = vld_r;
  assign dout      = res_r;

endmodule

@@ hdl/binary_frame_sync_sum16_check_top.sv @@
// ----------------------------------------------------------------------------
// binary_frame_sync_sum16_check_top
// Byte-stream frame synchronizer with a 16-bit byte-sum check.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one receiver byte per transaction (valid/ready).
//   out_* : frame bytes from the length byte onward, with index, message id,
//           last flag and status; header bytes give no transaction.
//   cfg_* : writes max_frame_len; always ready, write only while idle.
// Throughput is one byte per cycle while out_ready is high, set by the single
// input register feeding the single result register. A result goes from the
// input register through the core into the result register, then to out_*.
// A stalled receiver (out_ready low) holds the result register; the input
// register then fills and in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, returns to header
// hunt with a cleared sync window and sets max_frame_len to 261.
// ----------------------------------------------------------------------------
module binary_frame_sync_sum16_check_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bfs_pkg::ByteW-1:0]   in_data_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfs_pkg::IdxW-1:0]    cfg_max_frame_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bfs_pkg::ByteW-1:0]   out_byte,
  output logic [bfs_pkg::IdxW-1:0]    out_byte_index,
  output logic [bfs_pkg::ByteW-1:0]   out_msg_id,
  output logic                        out_is_last,
  output logic [bfs_pkg::StatW-1:0]   out_status
);

  logic [bfs_pkg::IdxW-1:0]  max_len_r;
  logic                      in_vld_r, in_vld_nxt;
  logic [bfs_pkg::ByteW-1:0] in_byte_r;
  logic                      step;
  logic                      res_valid;
  logic                      out_free;
  bfs_pkg::result_t          res;
  bfs_pkg::result_t          out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= bfs_pkg::MaxLenRst;
    end else if (cfg_valid) begin
      max_len_r <= cfg_max_frame_len;
    end
  end

  // byte in the input register is processed once the result side can take it
  assign step     = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  bfs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .din       (in_byte_r),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  bfs_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .din       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .dout      (out_res)
  );

  assign out_byte       = out_res.data;
  assign out_byte_index = out_res.index;
  assign out_msg_id     = out_res.id;
  assign out_is_last    = out_res.last;
  assign out_status     = out_res.status;

endmodule
